FILE: rtl/assert_macros.svh
// Assertion macros shared by the integer-to-radix-digits RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/i2r_pkg.sv
// Shared types, constants and helpers for the integer-to-radix-digits block.
// No dependencies; imported by every module of the block except i2r_ram.
package i2r_pkg;

  localparam int VALUE_W   = 31;
  localparam int RADIX_W   = 5;
  localparam int CHAR_W    = 7;
  localparam int DIGIT_W   = 4;
  localparam int DIV_W     = 32;   // dividend padded to a multiple of the step size
  localparam int DIV_BITS  = 8;    // quotient bits resolved per cycle
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'd48;   // '0'
  localparam logic [CHAR_W-1:0]  CHAR_A    = 7'd97;   // 'a'
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  // Input beat
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } item_t;

  // Output beat
  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } result_t;

  // Queued job: value plus radix already clamped to 2..16
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_LD
  } back_state_t;

  // Digit value to lower-case ASCII
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

FILE: rtl/i2r_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the digit store of the back end.
module i2r_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/i2r_front.sv
// Front end: accepts input beats, clamps the radix, and queues jobs (two deep).
// Depends on i2r_pkg and assert_macros.svh.
`include "assert_macros.svh"
module i2r_front (
  input  logic           clk,
  input  logic           rst,
  input  i2r_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_ready,
  output i2r_pkg::job_t  job,
  output logic           job_valid,
  input  logic           job_ready
);
  import i2r_pkg::*;

  localparam int QDEPTH = 2;

  job_t       q [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  job_t       clamped;
  logic       push;
  logic       pop;

  // Radix clamp: below two acts as two, above sixteen as sixteen
  always_comb begin
    clamped.value = item.value;
    priority if (item.radix < RADIX_MIN) begin
      clamped.radix = RADIX_MIN;
    end else if (item.radix > RADIX_MAX) begin
      clamped.radix = RADIX_MAX;
    end else begin
      clamped.radix = item.radix;
    end
  end

  assign item_ready = (count != 2'(QDEPTH));
  assign push       = item_valid && item_ready;
  assign job_valid  = (count != 2'd0);
  assign pop        = job_valid && job_ready;
  assign job        = q[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= clamped;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_AT(a_q_bound, clk, rst, count <= 2'(QDEPTH), "queue fill level out of range")
  `ASSERT_NEXT(a_q_grow, clk, rst, push && !pop, count == $past(count) + 2'd1, "push lost")

endmodule

FILE: rtl/i2r_back.sv
// Back end: divides the queued value by the radix one digit at a time into the
// digit RAM, then reads the digits back most significant first into the result
// register. Depends on i2r_pkg, i2r_ram and assert_macros.svh.
`include "assert_macros.svh"
module i2r_back #(
  parameter int DIGIT_SLOTS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  i2r_pkg::job_t    job,
  input  logic             job_valid,
  output logic             job_ready,
  output i2r_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_ready
);
  import i2r_pkg::*;

  localparam int AW = $clog2(DIGIT_SLOTS);
  localparam int CW = $clog2(DIGIT_SLOTS + 1);

  back_state_t          state, state_next;
  logic [DIV_W-1:0]     div_q, div_q_next;      // dividend shifting out, quotient in
  logic [DIGIT_W-1:0]   rem, rem_next;          // partial remainder
  logic [RADIX_W-1:0]   radix, radix_next;
  logic [STEP_W-1:0]    step, step_next;
  logic [CW-1:0]        cnt, cnt_next;          // digits stored
  logic [AW-1:0]        rd_ptr, rd_ptr_next;
  logic                 out_valid, out_valid_next;
  result_t              out_data, out_data_next;

  logic [DIV_W-1:0]     dq_step;
  logic [DIGIT_W-1:0]   rem_step;
  logic                 ram_we;
  logic [DIGIT_W-1:0]   ram_rdata;

  // Eight restoring division steps on the narrow remainder
  always_comb begin
    logic [DIGIT_W:0] t;
    dq_step  = div_q;
    rem_step = rem;
    for (int i = 0; i < DIV_BITS; i++) begin
      t       = {rem_step, dq_step[DIV_W-1]};
      dq_step = {dq_step[DIV_W-2:0], 1'b0};
      if (t >= radix) begin
        rem_step   = DIGIT_W'(t - radix);
        dq_step[0] = 1'b1;
      end else begin
        rem_step = t[DIGIT_W-1:0];
      end
    end
  end

  i2r_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_SLOTS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[AW-1:0]),
    .wdata (rem_step),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  assign job_ready    = (state == ST_IDLE);
  assign result_valid = out_valid;
  assign result       = out_data;
  assign ram_we       = (state == ST_DIV) && (step == STEP_W'(DIV_STEPS - 1));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
      cnt       <= '0;
    end else begin
      out_valid <= out_valid_next;
      step      <= step_next;
      cnt       <= cnt_next;
    end
    div_q    <= div_q_next;
    rem      <= rem_next;
    radix    <= radix_next;
    rd_ptr   <= rd_ptr_next;
    out_data <= out_data_next;
  end

  // Next state and datapath control
  always_comb begin
    logic [CW-1:0] cnt_inc;
    state_next     = state;
    div_q_next     = div_q;
    rem_next       = rem;
    radix_next     = radix;
    step_next      = step;
    cnt_next       = cnt;
    rd_ptr_next    = rd_ptr;
    out_valid_next = out_valid && !result_ready;
    out_data_next  = out_data;
    cnt_inc        = cnt + CW'(1);

    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          div_q_next = {1'b0, job.value};
          radix_next = job.radix;
          rem_next   = '0;
          step_next  = '0;
          cnt_next   = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        div_q_next = dq_step;
        rem_next   = rem_step;
        step_next  = step + STEP_W'(1);
        if (ram_we) begin
          // One digit complete: stored at cnt
          cnt_next = cnt_inc;
          rem_next = '0;
          if (dq_step == '0 || cnt_inc == CW'(DIGIT_SLOTS)) begin
            rd_ptr_next = cnt[AW-1:0];
            state_next  = ST_RD;
          end
        end
      end
      ST_RD: begin
        // RAM samples rd_ptr this cycle
        state_next = ST_LD;
      end
      ST_LD: begin
        if (!out_valid || result_ready) begin
          out_valid_next           = 1'b1;
          out_data_next.digit_char = digit_to_char(ram_rdata);
          out_data_next.last       = (rd_ptr == '0);
          if (rd_ptr == '0) begin
            state_next = ST_IDLE;
          end else begin
            rd_ptr_next = rd_ptr - AW'(1);
            state_next  = ST_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_AT(a_rem_lt_radix, clk, rst, state != ST_DIV || rem < radix, "remainder not below radix")
  `ASSERT_AT(a_cnt_bound, clk, rst, cnt <= CW'(DIGIT_SLOTS), "digit count past store size")
  `ASSERT_NEXT(a_ld_after_rd, clk, rst, state == ST_RD, state == ST_LD, "read not followed by load")

endmodule

FILE: rtl/integer_to_radix_digits.sv
// Top level of the integer-to-radix-digits converter.
// Depends on i2r_pkg, i2r_front and i2r_back.
//
// Converts a 31-bit unsigned value into lower-case ASCII digits of radix 2..16
// (radix 0 and 1 act as 2, radix 17..31 as 16), one result beat per digit, most
// significant first, with last set on the final digit; zero gives a single '0'.
// A two-deep job queue sits between input and converter, so up to two values
// may be taken while an earlier one is still being converted. The shared
// divider resolves eight quotient bits per cycle, working through the whole
// dividend once for each digit, and each digit then comes back out of the
// registered-read digit RAM through the ST_RD and ST_LD states into the result
// register, waiting in ST_LD while the result side stalls.
module integer_to_radix_digits #(
  parameter int DIGIT_SLOTS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  i2r_pkg::item_t   item,
  input  logic             item_valid,
  output logic             item_ready,
  output i2r_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_ready
);
  import i2r_pkg::*;

  job_t job;
  logic job_valid;
  logic job_ready;

  i2r_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .job        (job),
    .job_valid  (job_valid),
    .job_ready  (job_ready)
  );

  i2r_back #(
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (job),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule
